FILE: rtl/jesp_pkg.sv
// Package for the export stream parser: result kinds, error codes, prefix
// lookups and the queue word type. No dependencies.
`timescale 1ns / 1ps
package jesp_pkg;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ENTRY = 2'd2;
   localparam logic [1:0] KIND_ERR   = 2'd3;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_TOO_BIG = 2'd1;
   localparam logic [1:0] ERR_NO_TERM = 2'd2;
   localparam logic [1:0] ERR_STAMP   = 2'd3;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [4:0] LEN_CURSOR = 5'd9;
   localparam logic [4:0] LEN_REAL   = 5'd21;
   localparam logic [4:0] LEN_MONO   = 5'd22;

   localparam logic [2:0] CAND_CURSOR = 3'b001;
   localparam logic [2:0] CAND_REAL   = 3'b010;
   localparam logic [2:0] CAND_MONO   = 3'b100;

   // One result as it leaves the parser (before stamps are attached).
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] err;
      logic       last;
   } result_type;

   // Byte of "__CURSOR=" at position p.
   function automatic logic [7:0] cursor_char(input logic [4:0] p);
      logic [7:0] c;
      case (p)
         5'd0, 5'd1: c = 8'h5F;
         5'd2: c = "C";
         5'd3: c = "U";
         5'd4: c = "R";
         5'd5: c = "S";
         5'd6: c = "O";
         5'd7: c = "R";
         5'd8: c = "=";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Byte of the realtime stamp line prefix at position p.
   function automatic logic [7:0] real_char(input logic [4:0] p);
      logic [7:0] c;
      case (p)
         5'd0, 5'd1, 5'd10: c = 8'h5F;
         5'd2: c = "R";
         5'd3: c = "E";
         5'd4: c = "A";
         5'd5: c = "L";
         5'd6: c = "T";
         5'd7: c = "I";
         5'd8: c = "M";
         5'd9: c = "E";
         5'd11: c = "T";
         5'd12: c = "I";
         5'd13: c = "M";
         5'd14: c = "E";
         5'd15: c = "S";
         5'd16: c = "T";
         5'd17: c = "A";
         5'd18: c = "M";
         5'd19: c = "P";
         5'd20: c = "=";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Byte of the monotonic stamp line prefix at position p.
   function automatic logic [7:0] mono_char(input logic [4:0] p);
      logic [7:0] c;
      case (p)
         5'd0, 5'd1, 5'd11: c = 8'h5F;
         5'd2: c = "M";
         5'd3: c = "O";
         5'd4: c = "N";
         5'd5: c = "O";
         5'd6: c = "T";
         5'd7: c = "O";
         5'd8: c = "N";
         5'd9: c = "I";
         5'd10: c = "C";
         5'd12: c = "T";
         5'd13: c = "I";
         5'd14: c = "M";
         5'd15: c = "E";
         5'd16: c = "S";
         5'd17: c = "T";
         5'd18: c = "A";
         5'd19: c = "M";
         5'd20: c = "P";
         5'd21: c = "=";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/jesp_if.sv
// Valid/ready channel interfaces for the export stream parser.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
interface jesp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface jesp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic [63:0] realtime_stamp;
   logic [63:0] monotonic_stamp;
   logic [1:0]  error_code;
   logic        last;
   modport source (output valid, output out_kind, output out_byte, output realtime_stamp,
                   output monotonic_stamp, output error_code, output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input realtime_stamp,
                 input monotonic_stamp, input error_code, input last, output ready);
endinterface

interface jesp_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/jesp_front.sv
// Front part: takes one stream byte a cycle while the queue has room, runs
// the parse state and produces up to two results into the queue. Depends on jesp_pkg.
`timescale 1ns / 1ps
module jesp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic [31:0]          max_size,
   input  logic                 q_room,
   output logic                 in_ready,
   output logic                 push,
   output logic [1:0]           push_count,
   output jesp_pkg::result_type res0,
   output jesp_pkg::result_type res1,
   output logic                 stamp_we,
   output logic                 stamp_sel_real,
   output logic [63:0]          stamp_val
);
   import jesp_pkg::*;

   typedef enum logic [3:0] {
      PH_START, PH_TEXT, PH_VALUE, PH_DUNDER, PH_STAMP,
      PH_SKIP, PH_LEN, PH_DATA, PH_FINISH, PH_HALT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        held_ff, held_in;
   logic [4:0]  pos_ff, pos_in;
   logic [2:0]  cand_ff, cand_in;
   logic [2:0]  lidx_ff, lidx_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   logic        field_ff, field_in;

   logic        fire;
   logic [2:0]  cmatch;
   logic [4:0]  pos_nx;
   logic [3:0]  digit;
   logic [67:0] acc_x10;
   logic [64:0] acc_new;
   logic        acc_ovf;
   logic [63:0] acc_len;

   assign in_ready = q_room;
   assign fire = in_valid && in_ready;

   // Decimal step and prefix matching
   assign digit   = in_byte[3:0];
   assign acc_x10 = {4'd0, acc_ff} * 68'd10;
   assign acc_new = {1'b0, acc_x10[63:0]} + {61'd0, digit};
   assign acc_ovf = (acc_x10[67:64] != 4'd0) || acc_new[64];
   assign pos_nx  = pos_ff + 5'd1;
   assign acc_len = acc_ff | ({56'd0, in_byte} << {lidx_ff, 3'b000});
   always_comb begin
      cmatch[0] = cand_ff[0] && (pos_ff < LEN_CURSOR) && (cursor_char(pos_ff) == in_byte);
      cmatch[1] = cand_ff[1] && (pos_ff < LEN_REAL) && (real_char(pos_ff) == in_byte);
      cmatch[2] = cand_ff[2] && (pos_ff < LEN_MONO) && (mono_char(pos_ff) == in_byte);
   end

   function automatic result_type mk(input logic [1:0] k, input logic [7:0] d,
                                     input logic [1:0] e);
      result_type r;
      r.kind = k;
      r.data = (k == KIND_BYTE) ? d : 8'd0;
      r.err  = (k == KIND_ERR) ? e : ERR_NONE;
      r.last = 1'b0;
      return r;
   endfunction

   // Next-state and result selection
   always_comb begin
      result_type r0, r1;
      logic [1:0] n;
      logic [7:0] tb;
      phase_type  tph;
      r0 = mk(KIND_BYTE, 8'd0, ERR_NONE);
      r1 = mk(KIND_BYTE, 8'd0, ERR_NONE);
      n = 2'd0;
      phase_in = phase_ff; held_in = held_ff; pos_in = pos_ff; cand_in = cand_ff;
      lidx_in = lidx_ff; rem_in = rem_ff; acc_in = acc_ff; seen_in = seen_ff;
      field_in = field_ff;
      stamp_we = 1'b0; stamp_sel_real = cand_ff[1]; stamp_val = acc_ff;
      // ordinary text name byte
      if (in_byte == CH_EQ) begin
         tb = CH_EQ; tph = PH_VALUE;
      end else if (in_byte == CH_NL) begin
         tb = CH_EQ; tph = PH_LEN;
      end else begin
         tb = in_byte; tph = PH_TEXT;
      end
      case (phase_ff)
         PH_START: begin
            if (held_ff) begin
               held_in = 1'b0;
               if (in_byte == CH_UNDER) begin
                  phase_in = PH_DUNDER; pos_in = 5'd2; cand_in = 3'b111;
               end else begin
                  field_in = 1'b1;
                  r0 = mk(KIND_BYTE, CH_UNDER, ERR_NONE);
                  r1 = mk(KIND_BYTE, tb, ERR_NONE);
                  n = 2'd2; phase_in = tph;
                  if (tph == PH_LEN) begin
                     lidx_in = 3'd0; acc_in = 64'd0;
                  end
               end
            end else if (in_byte == CH_NL) begin
               if (field_ff) begin
                  r0 = mk(KIND_ENTRY, 8'd0, ERR_NONE); n = 2'd1;
               end
               field_in = 1'b0;
            end else if (in_byte == CH_UNDER) begin
               held_in = 1'b1;
            end else begin
               field_in = 1'b1;
               r0 = mk(KIND_BYTE, tb, ERR_NONE); n = 2'd1; phase_in = tph;
               if (tph == PH_LEN) begin
                  lidx_in = 3'd0; acc_in = 64'd0;
               end
            end
         end
         PH_TEXT: begin
            r0 = mk(KIND_BYTE, tb, ERR_NONE); n = 2'd1; phase_in = tph;
            if (tph == PH_LEN) begin
               lidx_in = 3'd0; acc_in = 64'd0;
            end
         end
         PH_VALUE: begin
            if (in_byte == CH_NL) begin
               r0 = mk(KIND_END, 8'd0, ERR_NONE); phase_in = PH_START;
            end else begin
               r0 = mk(KIND_BYTE, in_byte, ERR_NONE);
            end
            n = 2'd1;
         end
         PH_DUNDER: begin
            if (in_byte == CH_NL) begin
               phase_in = PH_START;
            end else begin
               cand_in = cmatch; pos_in = pos_nx;
               if (cmatch == 3'd0 || (cmatch[0] && pos_nx == LEN_CURSOR)) begin
                  phase_in = PH_SKIP;
               end else if ((cmatch[1] && pos_nx == LEN_REAL) ||
                            (cmatch[2] && pos_nx == LEN_MONO)) begin
                  phase_in = PH_STAMP; acc_in = 64'd0; seen_in = 1'b0;
               end
            end
         end
         PH_STAMP: begin
            if (in_byte == CH_NL) begin
               if (!seen_ff) begin
                  r0 = mk(KIND_ERR, 8'd0, ERR_STAMP); n = 2'd1; phase_in = PH_HALT;
               end else begin
                  stamp_we = 1'b1; phase_in = PH_START;
               end
            end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
               if (acc_ovf) begin
                  r0 = mk(KIND_ERR, 8'd0, ERR_STAMP); n = 2'd1; phase_in = PH_HALT;
               end else begin
                  acc_in = acc_new[63:0]; seen_in = 1'b1;
               end
            end else begin
               r0 = mk(KIND_ERR, 8'd0, ERR_STAMP); n = 2'd1; phase_in = PH_HALT;
            end
         end
         PH_SKIP: begin
            if (in_byte == CH_NL) phase_in = PH_START;
         end
         PH_LEN: begin
            acc_in = acc_len; lidx_in = lidx_ff + 3'd1;
            if (lidx_ff == 3'd7) begin
               if (acc_len > {32'd0, max_size}) begin
                  r0 = mk(KIND_ERR, 8'd0, ERR_TOO_BIG); n = 2'd1; phase_in = PH_HALT;
               end else begin
                  rem_in = acc_len;
                  phase_in = (acc_len != 64'd0) ? PH_DATA : PH_FINISH;
               end
            end
         end
         PH_DATA: begin
            r0 = mk(KIND_BYTE, in_byte, ERR_NONE); n = 2'd1;
            rem_in = rem_ff - 64'd1;
            if (rem_ff == 64'd1) phase_in = PH_FINISH;
         end
         PH_FINISH: begin
            if (in_byte == CH_NL) begin
               r0 = mk(KIND_END, 8'd0, ERR_NONE); phase_in = PH_START;
            end else begin
               r0 = mk(KIND_ERR, 8'd0, ERR_NO_TERM); phase_in = PH_HALT;
            end
            n = 2'd1;
         end
         default: phase_in = PH_HALT;
      endcase
      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;
      res0 = r0; res1 = r1; push_count = n;
   end

   assign push = fire && (push_count != 2'd0);

   // Hold parse state, advance on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START; held_ff <= 1'b0; pos_ff <= 5'd0; cand_ff <= 3'b111;
         lidx_ff <= 3'd0; rem_ff <= 64'd0; acc_ff <= 64'd0; seen_ff <= 1'b0;
         field_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in; held_ff <= held_in; pos_ff <= pos_in; cand_ff <= cand_in;
         lidx_ff <= lidx_in; rem_ff <= rem_in; acc_ff <= acc_in; seen_ff <= seen_in;
         field_ff <= field_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT) else $error("halt left");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      push && res0.kind == KIND_ERR |-> res0.last && push_count == 2'd1)
      else $error("error not sole result");
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> !push) else $error("result after halt");
endmodule

FILE: rtl/jesp_back.sv
// Back part: a four-entry result queue, stamp registers, and the head-entry
// output toward the result channel. Depends on jesp_pkg.
`timescale 1ns / 1ps
module jesp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [1:0]           push_count,
   input  jesp_pkg::result_type res0,
   input  jesp_pkg::result_type res1,
   input  logic                 stamp_we,
   input  logic                 stamp_sel_real,
   input  logic [63:0]          stamp_val,
   output logic                 q_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [1:0]           out_kind,
   output logic [7:0]           out_byte,
   output logic [63:0]          out_real,
   output logic [63:0]          out_mono,
   output logic [1:0]           out_err,
   output logic                 out_last
);
   import jesp_pkg::*;

   result_type  mem_ff [4];
   logic [63:0] mreal_ff [4];
   logic [63:0] mmono_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;
   logic [63:0] real_ff, mono_ff;
   logic        pop;
   logic [2:0]  npush;

   assign npush  = push ? {1'b0, push_count} : 3'd0;
   assign q_room = (cnt_ff <= 3'd2) || ((cnt_ff == 3'd3) && out_ready);
   assign pop    = (cnt_ff != 3'd0) && out_ready;
   assign out_valid = cnt_ff != 3'd0;

   // Write results with the stamps held now, advance pointers
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= res0;
         mreal_ff[wp_ff] <= real_ff;
         mmono_ff[wp_ff] <= mono_ff;
         if (push_count == 2'd2) mem_ff[wp_ff + 2'd1] <= res1;
      end
      if (reset) begin
         wp_ff <= 2'd0; rp_ff <= 2'd0; cnt_ff <= 3'd0;
      end else begin
         wp_ff  <= wp_ff + npush[1:0];
         rp_ff  <= rp_ff + {1'b0, pop};
         cnt_ff <= cnt_ff + npush - {2'd0, pop};
      end
   end

   // Keep timestamps; each push copies them in beside its first word
   always_ff @(posedge clock) begin
      if (reset) begin
         real_ff <= 64'd0; mono_ff <= 64'd0;
      end else if (stamp_we) begin
         if (stamp_sel_real) real_ff <= stamp_val;
         else mono_ff <= stamp_val;
      end
   end

   // Drive head entry
   always_comb begin
      result_type h;
      h = mem_ff[rp_ff];
      out_kind = h.kind; out_byte = h.data; out_err = h.err; out_last = h.last;
      out_real = (h.kind == KIND_ENTRY) ? mreal_ff[rp_ff] : 64'd0;
      out_mono = (h.kind == KIND_ENTRY) ? mmono_ff[rp_ff] : 64'd0;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("queue overflow");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      push |-> q_room) else $error("push without room");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) == cnt_ff[1:0]) else $error("pointer mismatch");
endmodule

FILE: rtl/journal_export_stream_parser_top.sv
// Top level of the export stream parser: channel interfaces, config register,
// front parser and back result queue. Depends on jesp_pkg, jesp_if, front, back.
//
// Usage: stream bytes go in on req (valid/ready, in_byte); results come out on
// rsp (out_kind, out_byte, stamps, error_code, last), one word per handshake.
// csr writes max_binary_size (32 bits); write only while idle. Reset value is
// 805306368.
// Throughput: one byte per cycle while the queue has room; a byte causing two
// results is still taken in one handshake, the output side drains one result a
// cycle while rsp is ready. Each result is queued when its byte is accepted.
// A four-word result queue sits between the parser and the output, so the
// parser keeps taking bytes while rsp stalls until the queue is near full;
// req_ready then drops.
// Reset (synchronous) clears parse state, timestamps and the queue. After an
// error result the block consumes bytes silently until reset.
// Entry-complete words carry the timestamps held when they enter the queue,
// so a later timestamp line cannot change a word still waiting on rsp.
`timescale 1ns / 1ps
module journal_export_stream_parser_top (
   input logic       clock,
   input logic       reset,
   jesp_req_if.sink  req,
   jesp_rsp_if.source rsp,
   jesp_csr_if.sink  csr
);
   import jesp_pkg::*;

   logic [31:0] max_ff;
   logic        q_room, push, stamp_we, stamp_sel_real;
   logic [1:0]  push_count;
   logic [63:0] stamp_val;
   result_type  res0, res1;

   // Hold the size limit
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 32'd805306368;
      end else if (csr.valid) begin
         max_ff <= csr.data;
      end
   end

   jesp_front u_front (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_byte(req.in_byte),
      .max_size(max_ff), .q_room(q_room), .in_ready(req.ready), .push(push),
      .push_count(push_count), .res0(res0), .res1(res1), .stamp_we(stamp_we),
      .stamp_sel_real(stamp_sel_real), .stamp_val(stamp_val)
   );

   jesp_back u_back (
      .clock(clock), .reset(reset), .push(push), .push_count(push_count),
      .res0(res0), .res1(res1), .stamp_we(stamp_we && req.valid && req.ready),
      .stamp_sel_real(stamp_sel_real), .stamp_val(stamp_val), .q_room(q_room),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_kind(rsp.out_kind),
      .out_byte(rsp.out_byte), .out_real(rsp.realtime_stamp),
      .out_mono(rsp.monotonic_stamp), .out_err(rsp.error_code), .out_last(rsp.last)
   );
endmodule

FILE: verif/tb_journal_export_stream_parser_top.sv
// Testbench for the export stream parser: drives directed and random export
// streams, predicts every result word and checks rsp field by field.
// Depends on jesp_pkg, jesp_if and the journal_export_stream_parser_top RTL.
`timescale 1ns / 1ps
module tb_journal_export_stream_parser_top;
   import jesp_pkg::*;

   typedef enum logic [3:0] {
      P_START, P_TEXT, P_VALUE, P_DUNDER, P_STAMP, P_SKIP, P_LEN, P_DATA, P_FINISH, P_HALT
   } phase_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [63:0] rt;
      logic [63:0] mono;
      logic [1:0]  err;
      logic        last;
   } word_type;

   // Directed row: a byte and, where it is obvious, the single word it yields.
   typedef struct {
      logic [7:0] b;
      bit         typed;
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] err;
   } row_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   jesp_req_if req ();
   jesp_rsp_if rsp ();
   jesp_csr_if csr ();

   journal_export_stream_parser_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // Parser shadow state
   phase_type   ph;
   bit          held_us;
   int unsigned pos;
   logic [2:0]  cands;
   int unsigned len_idx;
   logic [63:0] remaining;
   logic [63:0] acc;
   bit          got_digit;
   logic [63:0] rt_keep;
   logic [63:0] mono_keep;
   bit          has_field;
   logic [31:0] max_bin;

   word_type    expected_words[$];
   word_type    typed_words[$];
   int          errors;
   int          words_seen;
   int          bytes_sent;
   int          entries_seen;
   bit          quiet;
   longint      cycles;
   string       cursor_s = "__CURSOR=";
   string       real_s = {"__REALTIME", "_TIMESTAMP="};
   string       mono_s = {"__MONOTONIC", "_TIMESTAMP="};

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic report(input string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   function automatic void push_word(input logic [1:0] k, input logic [7:0] d,
                                     input logic [1:0] e);
      word_type w;
      w.kind = k;
      w.data = (k == KIND_BYTE) ? d : 8'h00;
      w.rt = (k == KIND_ENTRY) ? rt_keep : 64'd0;
      w.mono = (k == KIND_ENTRY) ? mono_keep : 64'd0;
      w.err = (k == KIND_ERR) ? e : ERR_NONE;
      w.last = 1'b0;
      expected_words.push_back(w);
   endfunction

   function automatic void name_byte(input logic [7:0] b);
      if (b == CH_EQ) begin
         ph = P_VALUE;
         push_word(KIND_BYTE, b, ERR_NONE);
      end else if (b == CH_NL) begin
         ph = P_LEN;
         len_idx = 0;
         acc = 0;
         push_word(KIND_BYTE, CH_EQ, ERR_NONE);
      end else begin
         ph = P_TEXT;
         push_word(KIND_BYTE, b, ERR_NONE);
      end
   endfunction

   function automatic bit pfx_hit(input string s, input int unsigned p, input logic [7:0] b);
      return p < s.len() && s[p] == b;
   endfunction

   // Advance the shadow parser by one byte and queue the words it yields.
   function automatic void parse_byte(input logic [7:0] b);
      int n0;
      logic [2:0] c;
      logic [63:0] d;
      n0 = expected_words.size();
      case (ph)
         P_START: begin
            if (held_us) begin
               held_us = 0;
               if (b == CH_UNDER) begin
                  ph = P_DUNDER;
                  pos = 2;
                  cands = 3'b111;
               end else begin
                  has_field = 1;
                  push_word(KIND_BYTE, CH_UNDER, ERR_NONE);
                  name_byte(b);
               end
            end else if (b == CH_NL) begin
               if (has_field) push_word(KIND_ENTRY, 0, ERR_NONE);
               has_field = 0;
            end else if (b == CH_UNDER) begin
               held_us = 1;
            end else begin
               has_field = 1;
               name_byte(b);
            end
         end
         P_TEXT: name_byte(b);
         P_VALUE: begin
            if (b == CH_NL) begin
               ph = P_START;
               push_word(KIND_END, 0, ERR_NONE);
            end else begin
               push_word(KIND_BYTE, b, ERR_NONE);
            end
         end
         P_DUNDER: begin
            if (b == CH_NL) begin
               ph = P_START;
            end else begin
               c = 0;
               if (cands[0] && pfx_hit(cursor_s, pos, b)) c[0] = 1;
               if (cands[1] && pfx_hit(real_s, pos, b)) c[1] = 1;
               if (cands[2] && pfx_hit(mono_s, pos, b)) c[2] = 1;
               cands = c;
               pos = (pos + 1) % 32;
               if (c == 0 || (c[0] && pos == 9)) begin
                  ph = P_SKIP;
               end else if ((c[1] && pos == 21) || (c[2] && pos == 22)) begin
                  ph = P_STAMP;
                  acc = 0;
                  got_digit = 0;
               end
            end
         end
         P_STAMP: begin
            if (b == CH_NL) begin
               if (!got_digit) begin
                  ph = P_HALT;
                  push_word(KIND_ERR, 0, ERR_STAMP);
               end else begin
                  if (cands[1]) rt_keep = acc;
                  else mono_keep = acc;
                  ph = P_START;
               end
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
               d = b - CH_ZERO;
               if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) begin
                  ph = P_HALT;
                  push_word(KIND_ERR, 0, ERR_STAMP);
               end else begin
                  acc = acc * 10 + d;
                  got_digit = 1;
               end
            end else begin
               ph = P_HALT;
               push_word(KIND_ERR, 0, ERR_STAMP);
            end
         end
         P_SKIP: if (b == CH_NL) ph = P_START;
         P_LEN: begin
            acc = acc | (64'(b) << (8 * len_idx));
            if (len_idx == 7) begin
               len_idx = 0;
               if (acc > 64'(max_bin)) begin
                  ph = P_HALT;
                  push_word(KIND_ERR, 0, ERR_TOO_BIG);
               end else begin
                  remaining = acc;
                  ph = (acc != 0) ? P_DATA : P_FINISH;
               end
            end else begin
               len_idx++;
            end
         end
         P_DATA: begin
            push_word(KIND_BYTE, b, ERR_NONE);
            if (remaining > 0) remaining--;
            if (remaining == 0) ph = P_FINISH;
         end
         P_FINISH: begin
            if (b == CH_NL) begin
               ph = P_START;
               push_word(KIND_END, 0, ERR_NONE);
            end else begin
               ph = P_HALT;
               push_word(KIND_ERR, 0, ERR_NO_TERM);
            end
         end
         default: ph = P_HALT;
      endcase
      if (expected_words.size() > n0)
         expected_words[expected_words.size() - 1].last = 1'b1;
   endfunction

   function automatic void reset_shadow();
      ph = P_START;
      held_us = 0;
      pos = 0;
      cands = 3'b111;
      len_idx = 0;
      remaining = 0;
      acc = 0;
      got_digit = 0;
      rt_keep = 0;
      mono_keep = 0;
      has_field = 0;
      max_bin = 32'd805306368;
   endfunction

   // Hand one byte to the block and predict its words once accepted.
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.in_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      parse_byte(b);
      bytes_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(input logic [31:0] v);
      csr.valid <= 1'b1;
      csr.data <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      max_bin = v;
   endtask

   task automatic send_number(input logic [63:0] v);
      string s;
      s = $sformatf("%0d", v);
      send_str(s);
   endtask

   // One well-formed entry with random fields, stamps and binary values.
   task automatic send_entry();
      int nf;
      int ln;
      logic [63:0] v;
      nf = $urandom_range(0, 4);
      for (int f = 0; f < nf; f++) begin
         case ($urandom_range(0, 5))
            0, 1: begin
               send_byte(8'(8'h41 + $urandom_range(0, 25)));
               ln = $urandom_range(0, 6);
               for (int i = 0; i < ln; i++) send_byte(8'($urandom_range(8'h41, 8'h5A)));
               send_byte(CH_EQ);
               ln = $urandom_range(0, 8);
               for (int i = 0; i < ln; i++) begin
                  v[7:0] = 8'($urandom_range(0, 255));
                  if (v[7:0] == CH_NL) v[7:0] = 8'hFF;
                  send_byte(v[7:0]);
               end
               send_byte(CH_NL);
            end
            2: begin
               send_str($urandom_range(0, 1) ? "_X" : "BIN");
               send_byte(CH_NL);
               ln = $urandom_range(0, 6);
               for (int i = 0; i < 8; i++) send_byte(i == 0 ? ln[7:0] : 8'h00);
               for (int i = 0; i < ln; i++) send_byte(8'($urandom_range(0, 255)));
               send_byte(CH_NL);
            end
            3: begin
               send_str(real_s);
               v = {$urandom, $urandom} >> $urandom_range(0, 63);
               send_number(v);
               send_byte(CH_NL);
            end
            4: begin
               send_str(mono_s);
               v = {$urandom, $urandom} >> $urandom_range(0, 63);
               send_number(v);
               send_byte(CH_NL);
            end
            default: begin
               send_str($urandom_range(0, 1) ? cursor_s : "__Q");
               send_byte(8'($urandom_range(8'h20, 8'h7E)));
               send_byte(CH_NL);
            end
         endcase
      end
      send_byte(CH_NL);
   endtask

   // Check each accepted rsp word against the oldest prediction.
   always @(posedge clock) begin
      word_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         words_seen++;
         if (rsp.out_kind == KIND_ENTRY) entries_seen++;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word kind %0d", rsp.out_kind));
         end else begin
            w = expected_words.pop_front();
            if (rsp.out_kind !== w.kind)
               report($sformatf("kind %0d, want %0d", rsp.out_kind, w.kind));
            if (rsp.out_byte !== w.data)
               report($sformatf("byte %h, want %h", rsp.out_byte, w.data));
            if (rsp.realtime_stamp !== w.rt)
               report($sformatf("realtime %0d, want %0d", rsp.realtime_stamp, w.rt));
            if (rsp.monotonic_stamp !== w.mono)
               report($sformatf("monotonic %0d, want %0d", rsp.monotonic_stamp, w.mono));
            if (rsp.error_code !== w.err)
               report($sformatf("error %0d, want %0d", rsp.error_code, w.err));
            if (rsp.last !== w.last)
               report($sformatf("last %0d, want %0d", rsp.last, w.last));
            if (typed_words.size() != 0) begin
               w = typed_words.pop_front();
               if (rsp.out_kind !== w.kind || rsp.out_byte !== w.data ||
                   rsp.error_code !== w.err)
                  report("directed row word differs from its typed value");
            end
         end
      end
   end

   // Receiver stalls in bursts, none in the quiet tail.
   initial begin
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("journal_export_stream_parser_top test failed");
            $finish;
         end
      end
   end

   initial begin
      row_type rows[$];
      word_type tw;
      logic [31:0] lims[4];
      errors = 0;
      words_seen = 0;
      bytes_sent = 0;
      entries_seen = 0;
      quiet = 0;
      reset_shadow();
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.in_byte <= 8'h00;
      csr.valid <= 1'b0;
      csr.data <= 32'h0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: text field, held underscore, empty-entry line,
      // binary field of length zero, then both stamps at their extremes.
      rows = '{
         '{8'h00, 1, KIND_BYTE, 8'h00, ERR_NONE}, '{CH_EQ, 1, KIND_BYTE, CH_EQ, ERR_NONE},
         '{8'hFF, 1, KIND_BYTE, 8'hFF, ERR_NONE}, '{CH_NL, 1, KIND_END, 0, ERR_NONE},
         '{CH_UNDER, 0, 0, 0, 0}, '{8'h41, 0, 0, 0, 0}, '{CH_EQ, 0, 0, 0, 0},
         '{CH_NL, 1, KIND_END, 0, ERR_NONE}, '{CH_NL, 0, 0, 0, 0},
         '{CH_NL, 0, 0, 0, 0}, '{8'h42, 1, KIND_BYTE, 8'h42, ERR_NONE},
         '{CH_NL, 1, KIND_BYTE, CH_EQ, ERR_NONE},
         '{8'h00, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0},
         '{8'h00, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0},
         '{8'h00, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0}, '{CH_NL, 1, KIND_END, 0, ERR_NONE}
      };
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            drain();
            tw.kind = rows[i].kind;
            tw.data = rows[i].data;
            tw.err = rows[i].err;
            typed_words.push_back(tw);
         end
         send_byte(rows[i].b);
         if (rows[i].typed) drain();
      end
      send_str(real_s);
      send_str("18446744073709551615\n");
      send_str(mono_s);
      send_str("0\n__CURSOR=x\n__\n\n");
      drain();

      // Random well-formed entries under several size limits; the reset-value
      // limit last, and no length ever trips a limit.
      lims = '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd805306368};
      for (int k = 0; k < 4; k++) begin
         drain();
         write_max(lims[k]);
         while (bytes_sent < 250 * (k + 1)) begin
            if (max_bin < 6) begin
               send_str("T=");
               send_byte(8'($urandom_range(0, 255) | 8'h80));
               send_str("\n\n");
            end else begin
               send_entry();
            end
         end
      end
      // Noise lines with random bytes (newline-terminated; no binary names).
      while (bytes_sent < 1100) begin
         send_byte(8'(8'h61 + $urandom_range(0, 25)));
         send_byte(CH_EQ);
         repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255) | 8'h01));
         send_str("\n\n");
      end

      // Quiet tail: no idling, ends in a halting error and silence after it.
      quiet = 1;
      drain();
      repeat (8) send_entry();
      case ($urandom_range(0, 2))
         0: begin
            send_str(real_s);
            send_str("99999999999999999999");
         end
         1: begin
            send_str("Z\n");
            repeat (7) send_byte(8'h00);
            send_byte(8'hFF);
         end
         default: begin
            send_str("Z\n");
            send_byte(8'h01);
            repeat (7) send_byte(8'h00);
            send_str("xy");
         end
      endcase
      repeat (20) send_byte(8'($urandom_range(0, 255)));
      req.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d stream bytes, %0d result words, %0d entry ends,",
               bytes_sent, words_seen, entries_seen);
      $display("four size limits and a final halting error.");
      if (errors == 0)
         $display("journal_export_stream_parser_top test passed");
      else
         $display("journal_export_stream_parser_top test failed");
      $finish;
   end

endmodule

FILE: journal_export_stream_parser_top.f
rtl/jesp_pkg.sv
rtl/jesp_if.sv
rtl/jesp_front.sv
rtl/jesp_back.sv
rtl/journal_export_stream_parser_top.sv
verif/tb_journal_export_stream_parser_top.sv
